// ===== hw/rtl/stt_pkg.sv =====
// Shared types and constants for the source text tokenizer.
// No dependencies; used by stt_scan, stt_resq and source_text_tokenizer_unit.
`default_nettype none

package stt_pkg;

	localparam int MAX_TOKEN_LEN = 255;
	localparam int OFFSET_BITS   = 32;
	localparam int LEN_CAP       = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

	localparam logic [4:0] TAB_RESET = 5'd4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LBRC   = 8'h7B;
	localparam logic [7:0] CH_RBRC   = 8'h7D;

	localparam logic [7:0] SENTINEL_LEN = 8'd13;

	localparam logic [2:0] K_SYMBOL   = 3'd0;
	localparam logic [2:0] K_NUMBER   = 3'd1;
	localparam logic [2:0] K_STRING   = 3'd2;
	localparam logic [2:0] K_OPERATOR = 3'd3;
	localparam logic [2:0] K_SENTINEL = 3'd4;

	typedef enum logic [2:0] {
		M_IDLE   = 3'd0,
		M_SYMBOL = 3'd1,
		M_NUMBER = 3'd2,
		M_STRING = 3'd3,
		M_OP     = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] line;
		logic [15:0] column;
		logic [31:0] offset;
		logic [7:0]  length;
		logic        bad;
		logic [7:0]  op_first;
		logic [7:0]  op_second;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stt_scan.sv =====
// Scanner state and per-byte decode: one text item in, up to two tokens out.
// Depends on stt_pkg.
`default_nettype none

module stt_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [7:0]        char_byte,
	input  wire logic              end_of_text,
	input  wire logic [4:0]        tab_width,
	output stt_pkg::push_t         push
);

	localparam int OB = stt_pkg::OFFSET_BITS;

	stt_pkg::mode_t mode_q, n_mode;
	logic          quote_single_q, n_quote_single;
	logic          seen_point_q, n_seen_point;
	logic [7:0]    pending_q, n_pending;
	logic [23:0]   start_line_q, n_start_line;
	logic [15:0]   start_col_q, n_start_col;
	logic [OB-1:0] start_off_q, n_start_off;
	logic [7:0]    len_q, n_len;
	logic [23:0]   line_q, n_line;
	logic [15:0]   col_q, n_col;
	logic [OB-1:0] byte_q, n_byte;

	stt_pkg::tok_t tok [2];
	logic [1:0]    cnt;
	logic          go_idle;
	logic          close_q;
	logic          dbl, cmp;
	logic [7:0]    len_inc;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic [15:0] col_plus(input logic [15:0] c, input logic [4:0] n);
		logic [16:0] s;
		s = {1'b0, c} + {12'd0, n};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic stt_pkg::tok_t mk(input logic [2:0] kind, input logic [23:0] line,
			input logic [15:0] column, input logic [31:0] offset, input logic [7:0] length,
			input logic bad, input logic [7:0] op1, input logic [7:0] op2);
		stt_pkg::tok_t t;
		t.kind      = kind;
		t.line      = line;
		t.column    = column;
		t.offset    = offset;
		t.length    = length;
		t.bad       = bad;
		t.op_first  = op1;
		t.op_second = op2;
		t.last      = 1'b0;
		return t;
	endfunction

	assign len_inc = (len_q < 8'(stt_pkg::LEN_CAP)) ? len_q + 8'd1 : len_q;

	always_comb begin
		close_q = quote_single_q ? (char_byte == stt_pkg::CH_SQUOTE)
			: (char_byte == stt_pkg::CH_DQUOTE);
		dbl = (pending_q == stt_pkg::CH_EQ || pending_q == stt_pkg::CH_AMP
			|| pending_q == stt_pkg::CH_BAR) && char_byte == pending_q;
		cmp = (pending_q == stt_pkg::CH_PLUS || pending_q == stt_pkg::CH_MINUS
			|| pending_q == stt_pkg::CH_STAR || pending_q == stt_pkg::CH_SLASH
			|| pending_q == stt_pkg::CH_PCT) && char_byte == stt_pkg::CH_EQ;
	end

	always_comb begin
		n_mode         = mode_q;
		n_quote_single = quote_single_q;
		n_seen_point   = seen_point_q;
		n_pending      = pending_q;
		n_start_line   = start_line_q;
		n_start_col    = start_col_q;
		n_start_off    = start_off_q;
		n_len          = len_q;
		n_line         = line_q;
		n_col          = col_q;
		n_byte         = byte_q;
		tok[0]         = '0;
		tok[1]         = '0;
		cnt            = 2'd0;
		go_idle        = 1'b0;
		if (end_of_text || char_byte == stt_pkg::CH_NUL) begin
			unique case (mode_q)
				stt_pkg::M_SYMBOL: begin
					tok[0] = mk(stt_pkg::K_SYMBOL, start_line_q, start_col_q,
						32'(start_off_q), len_q, 1'b0, 8'd0, 8'd0);
					cnt = 2'd1;
				end
				stt_pkg::M_NUMBER: begin
					tok[0] = mk(stt_pkg::K_NUMBER, start_line_q, start_col_q,
						32'(start_off_q), len_q, 1'b0, 8'd0, 8'd0);
					cnt = 2'd1;
				end
				stt_pkg::M_STRING: begin
					tok[0] = mk(stt_pkg::K_STRING, start_line_q, start_col_q,
						32'(start_off_q), len_q, 1'b1, 8'd0, 8'd0);
					cnt = 2'd1;
				end
				stt_pkg::M_OP: begin
					tok[0] = mk(stt_pkg::K_OPERATOR, start_line_q, start_col_q,
						32'(start_off_q), 8'd1, 1'b0, pending_q, 8'd0);
					cnt = 2'd1;
				end
				default: begin
				end
			endcase
			tok[cnt[0]] = mk(stt_pkg::K_SENTINEL, 24'd0, 16'd0, 32'(byte_q),
				stt_pkg::SENTINEL_LEN, 1'b0, 8'd0, 8'd0);
			cnt = cnt + 2'd1;
			n_mode         = stt_pkg::M_IDLE;
			n_quote_single = 1'b0;
			n_seen_point   = 1'b0;
			n_pending      = 8'd0;
			n_start_line   = 24'd0;
			n_start_col    = 16'd0;
			n_start_off    = '0;
			n_len          = 8'd0;
			n_line         = 24'd1;
			n_col          = 16'd1;
			n_byte         = '0;
		end else begin
			n_byte = (&byte_q) ? byte_q : byte_q + OB'(1);
			unique case (mode_q)
				stt_pkg::M_SYMBOL: begin
					if (is_letter(char_byte) || is_digit(char_byte)
							|| char_byte == stt_pkg::CH_UNDER) begin
						n_len = len_inc;
						n_col = col_plus(col_q, 5'd1);
					end else begin
						tok[0] = mk(stt_pkg::K_SYMBOL, start_line_q, start_col_q,
							32'(start_off_q), len_q, 1'b0, 8'd0, 8'd0);
						cnt     = 2'd1;
						n_mode  = stt_pkg::M_IDLE;
						go_idle = 1'b1;
					end
				end
				stt_pkg::M_NUMBER: begin
					if (is_digit(char_byte)
							|| (char_byte == stt_pkg::CH_POINT && !seen_point_q)) begin
						if (char_byte == stt_pkg::CH_POINT) begin
							n_seen_point = 1'b1;
						end
						n_len = len_inc;
						n_col = col_plus(col_q, 5'd1);
					end else begin
						tok[0] = mk(stt_pkg::K_NUMBER, start_line_q, start_col_q,
							32'(start_off_q), len_q, char_byte == stt_pkg::CH_POINT,
							8'd0, 8'd0);
						cnt     = 2'd1;
						n_mode  = stt_pkg::M_IDLE;
						go_idle = char_byte != stt_pkg::CH_POINT;
					end
				end
				stt_pkg::M_STRING: begin
					if (close_q) begin
						tok[0] = mk(stt_pkg::K_STRING, start_line_q, start_col_q,
							32'(start_off_q), len_q, 1'b0, 8'd0, 8'd0);
						cnt    = 2'd1;
						n_mode = stt_pkg::M_IDLE;
					end else begin
						n_len = len_inc;
					end
					n_col = col_plus(col_q, 5'd1);
				end
				stt_pkg::M_OP: begin
					if (dbl || cmp) begin
						tok[0] = mk(stt_pkg::K_OPERATOR, start_line_q, start_col_q,
							32'(start_off_q), 8'd2, 1'b0, pending_q, char_byte);
						n_col = col_plus(col_q, 5'd1);
					end else begin
						tok[0] = mk(stt_pkg::K_OPERATOR, start_line_q, start_col_q,
							32'(start_off_q), 8'd1, 1'b0, pending_q, 8'd0);
						go_idle = 1'b1;
					end
					cnt       = 2'd1;
					n_mode    = stt_pkg::M_IDLE;
					n_pending = 8'd0;
				end
				default: begin
					go_idle = 1'b1;
				end
			endcase
			if (go_idle) begin
				if (char_byte == stt_pkg::CH_NL) begin
					n_col  = 16'd1;
					n_line = (&line_q) ? line_q : line_q + 24'd1;
				end else if (char_byte == stt_pkg::CH_SPACE) begin
					n_col = col_plus(col_q, 5'd1);
				end else if (char_byte == stt_pkg::CH_TAB) begin
					n_col = col_plus(col_q, tab_width);
				end else if (is_letter(char_byte) || is_digit(char_byte)) begin
					n_start_line = line_q;
					n_start_col  = col_q;
					n_start_off  = byte_q;
					n_len        = 8'd1;
					n_seen_point = 1'b0;
					n_mode       = is_letter(char_byte) ? stt_pkg::M_SYMBOL
						: stt_pkg::M_NUMBER;
					n_col        = col_plus(col_q, 5'd1);
				end else if (char_byte == stt_pkg::CH_DQUOTE
						|| char_byte == stt_pkg::CH_SQUOTE) begin
					n_start_line   = line_q;
					n_start_col    = col_q;
					n_start_off    = (&byte_q) ? byte_q : byte_q + OB'(1);
					n_len          = 8'd0;
					n_quote_single = char_byte == stt_pkg::CH_SQUOTE;
					n_mode         = stt_pkg::M_STRING;
					n_col          = col_plus(col_q, 5'd1);
				end else if (char_byte == stt_pkg::CH_EQ || char_byte == stt_pkg::CH_AMP
						|| char_byte == stt_pkg::CH_BAR || char_byte == stt_pkg::CH_PLUS
						|| char_byte == stt_pkg::CH_MINUS || char_byte == stt_pkg::CH_STAR
						|| char_byte == stt_pkg::CH_SLASH || char_byte == stt_pkg::CH_PCT)
						begin
					n_start_line = line_q;
					n_start_col  = col_q;
					n_start_off  = byte_q;
					n_pending    = char_byte;
					n_mode       = stt_pkg::M_OP;
					n_col        = col_plus(col_q, 5'd1);
				end else if (char_byte == stt_pkg::CH_LPAR || char_byte == stt_pkg::CH_RPAR
						|| char_byte == stt_pkg::CH_LBRK || char_byte == stt_pkg::CH_RBRK
						|| char_byte == stt_pkg::CH_LBRC || char_byte == stt_pkg::CH_RBRC)
						begin
					tok[cnt[0]] = mk(stt_pkg::K_OPERATOR, line_q, col_q, 32'(byte_q),
						8'd1, 1'b0, char_byte, 8'd0);
					cnt   = cnt + 2'd1;
					n_col = col_plus(col_q, 5'd1);
				end
			end
		end
		if (cnt == 2'd2) begin
			tok[1].last = 1'b1;
		end else if (cnt == 2'd1) begin
			tok[0].last = 1'b1;
		end
	end

	always_comb begin
		push.cnt  = advance ? cnt : 2'd0;
		push.tok0 = tok[0];
		push.tok1 = tok[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= stt_pkg::M_IDLE;
			quote_single_q <= 1'b0;
			seen_point_q   <= 1'b0;
			pending_q      <= 8'd0;
			start_line_q   <= 24'd0;
			start_col_q    <= 16'd0;
			start_off_q    <= '0;
			len_q          <= 8'd0;
			line_q         <= 24'd1;
			col_q          <= 16'd1;
			byte_q         <= '0;
		end else if (advance) begin
			mode_q         <= n_mode;
			quote_single_q <= n_quote_single;
			seen_point_q   <= n_seen_point;
			pending_q      <= n_pending;
			start_line_q   <= n_start_line;
			start_col_q    <= n_start_col;
			start_off_q    <= n_start_off;
			len_q          <= n_len;
			line_q         <= n_line;
			col_q          <= n_col;
			byte_q         <= n_byte;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_resq.sv =====
// Four-entry token queue: takes up to two tokens per cycle, hands out one.
// Depends on stt_pkg.
`default_nettype none

module stt_resq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stt_pkg::push_t push,
	input  wire logic           pop,
	output stt_pkg::tok_t       head,
	output logic                valid,
	output logic                room
);

	stt_pkg::tok_t mem_q [4];
	logic [1:0]    wr_q;
	logic [1:0]    rd_q;
	logic [2:0]    cnt_q;

	assign head  = mem_q[rd_q];
	assign valid = cnt_q != 3'd0;
	assign room  = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + push.cnt;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.cnt} - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer: stream ports, tab width register.
// Depends on stt_pkg, stt_scan and stt_resq.
//
//  channel  | signals                              | moves
//  ---------+--------------------------------------+----------------------------
//  s_       | s_tvalid s_tready s_tdata s_tlast    | one text byte per item
//  m_       | m_tvalid m_tready m_tdata m_tuser    | one token per item
//           | m_tlast                              |
//  cfg_     | cfg_valid cfg_ready cfg_data         | tab width write
//
// An input item is decoded in the cycle it is accepted; its tokens (zero, one
// or two) are written into the registered token queue and leave from its head.
// One byte per cycle is taken while the four-entry token queue holds at most
// two tokens; a byte that yields two tokens is handed out as two output items.
// A stalled m_ side holds the queue head; s_tready drops while the queue holds
// three or more tokens.
// Reset clears scan state and the queue and sets the tab width to 4.
`default_nettype none

module source_text_tokenizer_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // char_byte
	input  wire logic         s_tlast,   // end_of_text
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// token_line, token_column, token_offset, token_length, token_bad,
	// op_first, op_second, zero pad
	output logic [103:0]      m_tdata,
	output logic [2:0]        m_tuser,   // token_kind
	output logic              m_tlast,   // last_of_run
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [4:0]   cfg_data   // tab_width
);

	logic           advance;
	logic           room;
	logic           pop;
	logic [4:0]     tab_q;
	stt_pkg::push_t push;
	stt_pkg::tok_t  head;

	assign cfg_ready = 1'b1;
	assign s_tready  = room;
	assign advance   = s_tvalid && s_tready;
	assign pop       = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= stt_pkg::TAB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tab_q <= cfg_data;
		end
	end

	stt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.char_byte   (s_tdata),
		.end_of_text (s_tlast),
		.tab_width   (tab_q),
		.push        (push)
	);

	stt_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.valid  (m_tvalid),
		.room   (room)
	);

	assign m_tdata = {7'd0, head.op_second, head.op_first, head.bad, head.length,
		head.offset, head.column, head.line};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	a_eot_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (s_tlast || s_tdata == stt_pkg::CH_NUL) |->
		push.cnt != 2'd0
		&& ((push.cnt == 2'd2) ? push.tok1.kind : push.tok0.kind) == stt_pkg::K_SENTINEL)
		else $error("end of text did not queue a sentinel as final token");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> !push.tok0.last && push.tok1.last)
		else $error("last_of_run misplaced on a two-token item");

	a_out_sentinel_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && m_tuser == stt_pkg::K_SENTINEL |-> m_tlast)
		else $error("sentinel token delivered without last_of_run");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> push.cnt == 2'd0)
		else $error("tokens pushed while queue lacks room");

endmodule

`default_nettype wire

// ===== sim/tb_source_text_tokenizer_unit.sv =====
// Testbench for source_text_tokenizer_unit: streams text bytes through the block,
// predicts every token with its own scanner model and checks each output item.
// Depends on stt_pkg and the tokenizer RTL.
module tb_source_text_tokenizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD   = 12;
	localparam int          RESET_CYCLES = 7;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          SETTLE       = 4;
	localparam int          TAIL_CYCLES  = 16;
	localparam logic [23:0] LINE_MAX     = 24'hFF_FFFF;
	localparam int unsigned COL_MAX      = 32'h0000_FFFF;

	localparam logic [7:0] HELD_OPS [8] = '{stt_pkg::CH_EQ, stt_pkg::CH_AMP,
		stt_pkg::CH_BAR, stt_pkg::CH_PLUS, stt_pkg::CH_MINUS, stt_pkg::CH_STAR,
		stt_pkg::CH_SLASH, stt_pkg::CH_PCT};
	localparam logic [7:0] BRACKETS [6] = '{stt_pkg::CH_LPAR, stt_pkg::CH_RPAR,
		stt_pkg::CH_LBRK, stt_pkg::CH_RBRK, stt_pkg::CH_LBRC, stt_pkg::CH_RBRC};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [4:0]   cfg_data = '0;

	source_text_tokenizer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// scanner model state
	logic [4:0]     tab_w = stt_pkg::TAB_RESET;
	stt_pkg::mode_t scan_st = stt_pkg::M_IDLE;
	logic           in_squote = 1'b0;
	logic           point_seen = 1'b0;
	logic [7:0]     op_held = '0;
	logic [23:0]    tok_line = '0;
	logic [15:0]    tok_col = '0;
	logic [31:0]    tok_off = '0;
	logic [7:0]     tok_len = '0;
	logic [23:0]    line_pos = 24'd1;
	logic [15:0]    col_pos = 16'd1;
	logic [31:0]    text_pos = '0;

	stt_pkg::tok_t  step_toks [$];
	stt_pkg::tok_t  token_q [$];
	logic [8:0]     text_buf [$];   // {end_of_text, char_byte}

	int             errors = 0;
	int             src_gap_pct = 7;
	int             sink_gap_pct = 86;
	int             sink_hold_left = 0;
	int unsigned    cycle_cnt = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function void restart_text();
		scan_st = stt_pkg::M_IDLE;
		in_squote = 1'b0;
		point_seen = 1'b0;
		op_held = '0;
		tok_line = '0;
		tok_col = '0;
		tok_off = '0;
		tok_len = '0;
		line_pos = 24'd1;
		col_pos = 16'd1;
		text_pos = '0;
	endfunction

	function void push_token(input logic [2:0] kind, input logic [23:0] line,
			input logic [15:0] col, input logic [31:0] off, input logic [7:0] len,
			input logic bad, input logic [7:0] op1, input logic [7:0] op2);
		stt_pkg::tok_t t;
		t.kind = kind;
		t.line = line;
		t.column = col;
		t.offset = off;
		t.length = len;
		t.bad = bad;
		t.op_first = op1;
		t.op_second = op2;
		t.last = 1'b0;
		step_toks.push_back(t);
	endfunction

	function void advance_col(input int unsigned n);
		int unsigned c;
		c = col_pos + n;
		col_pos = (c > COL_MAX) ? 16'hFFFF : c[15:0];
	endfunction

	function void grow_run();
		if (tok_len < stt_pkg::LEN_CAP)
			tok_len++;
	endfunction

	function void mark_start(input logic [31:0] off);
		tok_line = line_pos;
		tok_col = col_pos;
		tok_off = off;
	endfunction

	function void emit_run(input logic [2:0] kind, input logic bad);
		push_token(kind, tok_line, tok_col, tok_off, tok_len, bad, '0, '0);
		scan_st = stt_pkg::M_IDLE;
	endfunction

	function void emit_single_op();
		push_token(stt_pkg::K_OPERATOR, tok_line, tok_col, tok_off, 8'd1, 1'b0,
			op_held, '0);
		scan_st = stt_pkg::M_IDLE;
		op_held = '0;
	endfunction

	function void scan_fresh(input logic [7:0] b, input logic [31:0] pos);
		case (b)
			stt_pkg::CH_NL: begin
				col_pos = 16'd1;
				if (line_pos != LINE_MAX)
					line_pos++;
			end
			stt_pkg::CH_SPACE: advance_col(1);
			stt_pkg::CH_TAB: advance_col(32'(tab_w));
			stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE: begin
				mark_start((pos != '1) ? pos + 32'd1 : pos);
				tok_len = '0;
				in_squote = (b == stt_pkg::CH_SQUOTE);
				scan_st = stt_pkg::M_STRING;
				advance_col(1);
			end
			stt_pkg::CH_EQ, stt_pkg::CH_AMP, stt_pkg::CH_BAR, stt_pkg::CH_PLUS,
			stt_pkg::CH_MINUS, stt_pkg::CH_STAR, stt_pkg::CH_SLASH,
			stt_pkg::CH_PCT: begin
				mark_start(pos);
				op_held = b;
				scan_st = stt_pkg::M_OP;
				advance_col(1);
			end
			stt_pkg::CH_LPAR, stt_pkg::CH_RPAR, stt_pkg::CH_LBRK, stt_pkg::CH_RBRK,
			stt_pkg::CH_LBRC, stt_pkg::CH_RBRC: begin
				push_token(stt_pkg::K_OPERATOR, line_pos, col_pos, pos, 8'd1, 1'b0,
					b, '0);
				advance_col(1);
			end
			default: begin
				if (is_letter(b) || is_digit(b)) begin
					mark_start(pos);
					tok_len = 8'd1;
					point_seen = 1'b0;
					scan_st = is_letter(b) ? stt_pkg::M_SYMBOL : stt_pkg::M_NUMBER;
					advance_col(1);
				end
			end
		endcase
	endfunction

	// expected tokens for one accepted byte, appended to token_q
	function void predict_tokens(input logic [7:0] b, input logic eot);
		logic [31:0]   pos;
		logic          dbl;
		logic          cmp;
		stt_pkg::tok_t t;
		pos = text_pos;
		step_toks.delete();
		if (eot || b == stt_pkg::CH_NUL) begin
			case (scan_st)
				stt_pkg::M_SYMBOL: emit_run(stt_pkg::K_SYMBOL, 1'b0);
				stt_pkg::M_NUMBER: emit_run(stt_pkg::K_NUMBER, 1'b0);
				stt_pkg::M_STRING: emit_run(stt_pkg::K_STRING, 1'b1);
				stt_pkg::M_OP: emit_single_op();
				default: ;
			endcase
			push_token(stt_pkg::K_SENTINEL, '0, '0, text_pos, stt_pkg::SENTINEL_LEN,
				1'b0, '0, '0);
			restart_text();
		end else begin
			if (text_pos != '1)
				text_pos++;
			case (scan_st)
				stt_pkg::M_SYMBOL: begin
					if (is_letter(b) || is_digit(b) || b == stt_pkg::CH_UNDER) begin
						grow_run();
						advance_col(1);
					end else begin
						emit_run(stt_pkg::K_SYMBOL, 1'b0);
						scan_fresh(b, pos);
					end
				end
				stt_pkg::M_NUMBER: begin
					if (is_digit(b) || (b == stt_pkg::CH_POINT && !point_seen)) begin
						if (b == stt_pkg::CH_POINT)
							point_seen = 1'b1;
						grow_run();
						advance_col(1);
					end else if (b == stt_pkg::CH_POINT) begin
						emit_run(stt_pkg::K_NUMBER, 1'b1);
					end else begin
						emit_run(stt_pkg::K_NUMBER, 1'b0);
						scan_fresh(b, pos);
					end
				end
				stt_pkg::M_STRING: begin
					if (b == (in_squote ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE))
						emit_run(stt_pkg::K_STRING, 1'b0);
					else
						grow_run();
					advance_col(1);
				end
				stt_pkg::M_OP: begin
					dbl = (op_held == stt_pkg::CH_EQ || op_held == stt_pkg::CH_AMP ||
						op_held == stt_pkg::CH_BAR) && b == op_held;
					cmp = (op_held == stt_pkg::CH_PLUS || op_held == stt_pkg::CH_MINUS ||
						op_held == stt_pkg::CH_STAR || op_held == stt_pkg::CH_SLASH ||
						op_held == stt_pkg::CH_PCT) && b == stt_pkg::CH_EQ;
					if (dbl || cmp) begin
						push_token(stt_pkg::K_OPERATOR, tok_line, tok_col, tok_off, 8'd2,
							1'b0, op_held, b);
						scan_st = stt_pkg::M_IDLE;
						op_held = '0;
						advance_col(1);
					end else begin
						emit_single_op();
						scan_fresh(b, pos);
					end
				end
				default: scan_fresh(b, pos);
			endcase
		end
		if (step_toks.size() > 0) begin
			t = step_toks.pop_back();
			t.last = 1'b1;
			step_toks.push_back(t);
		end
		foreach (step_toks[i])
			token_q.push_back(step_toks[i]);
	endfunction

	function void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		stt_pkg::tok_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				$error("token_kind mismatch: expected none, got %0d", m_tuser);
				errors++;
			end else begin
				want = token_q.pop_front();
				check_field("token_kind", 32'(want.kind), 32'(m_tuser));
				check_field("token_line", 32'(want.line), 32'(m_tdata[23:0]));
				check_field("token_column", 32'(want.column), 32'(m_tdata[39:24]));
				check_field("token_offset", want.offset, m_tdata[71:40]);
				check_field("token_length", 32'(want.length), 32'(m_tdata[79:72]));
				check_field("token_bad", 32'(want.bad), 32'(m_tdata[80]));
				check_field("op_first", 32'(want.op_first), 32'(m_tdata[88:81]));
				check_field("op_second", 32'(want.op_second), 32'(m_tdata[96:89]));
				check_field("last_of_run", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (sink_hold_left > 0) begin
			sink_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < src_gap_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_tokens(b, eot);
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_item(text_buf[i][7:0], text_buf[i][8]);
		text_buf.delete();
	endtask

	// stop offering, then wait for every expected token
	task automatic drain();
		s_tvalid <= 1'b0;
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_tab(input logic [4:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tab_w = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_text(input string s);
		foreach (s[i])
			text_buf.push_back({1'b0, s[i]});
	endtask

	task automatic add_end();
		case ($urandom_range(0, 2))
			0: text_buf.push_back({1'b1, 8'($urandom_range(0, 255))});
			1: text_buf.push_back({1'b0, stt_pkg::CH_NUL});
			default: text_buf.push_back({1'b1, stt_pkg::CH_NUL});
		endcase
	endtask

	function automatic logic [7:0] rand_letter();
		int unsigned r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	task automatic add_digits(input int n);
		repeat (n) text_buf.push_back({1'b0, rand_digit()});
	endtask

	task automatic add_piece();
		int          r;
		logic [7:0]  q;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			text_buf.push_back({1'b0, rand_letter()});
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 2))
					0: c = rand_letter();
					1: c = rand_digit();
					default: c = stt_pkg::CH_UNDER;
				endcase
				text_buf.push_back({1'b0, c});
			end
		end else if (r < 35) begin
			add_digits($urandom_range(1, 5));
			if ($urandom_range(0, 1)) begin
				text_buf.push_back({1'b0, stt_pkg::CH_POINT});
				add_digits($urandom_range(0, 3));
				if ($urandom_range(0, 6) == 0) begin
					text_buf.push_back({1'b0, stt_pkg::CH_POINT});
					add_digits($urandom_range(0, 3));
				end
			end
		end else if (r < 45) begin
			q = $urandom_range(0, 1) ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE;
			text_buf.push_back({1'b0, q});
			repeat ($urandom_range(0, 10)) begin
				c = 8'($urandom_range(1, 255));
				while (c == q)
					c = 8'($urandom_range(1, 255));
				text_buf.push_back({1'b0, c});
			end
			if ($urandom_range(0, 9) != 0)
				text_buf.push_back({1'b0, q});
		end else if (r < 65) begin
			c = HELD_OPS[$urandom_range(0, 7)];
			text_buf.push_back({1'b0, c});
			case ($urandom_range(0, 3))
				0: text_buf.push_back({1'b0, c});
				1: text_buf.push_back({1'b0, stt_pkg::CH_EQ});
				2: text_buf.push_back({1'b0, HELD_OPS[$urandom_range(0, 7)]});
				default: ;
			endcase
		end else if (r < 73) begin
			text_buf.push_back({1'b0, BRACKETS[$urandom_range(0, 5)]});
		end else if (r < 90) begin
			case ($urandom_range(0, 2))
				0: text_buf.push_back({1'b0, stt_pkg::CH_SPACE});
				1: text_buf.push_back({1'b0, stt_pkg::CH_TAB});
				default: text_buf.push_back({1'b0, stt_pkg::CH_NL});
			endcase
		end else begin
			text_buf.push_back({1'b0, 8'($urandom_range(1, 255))});
		end
	endtask

	task automatic test_directed();
		add_text("Az_9 0.9.\t'\"'==%=&x{");
		text_buf.push_back({1'b0, 8'hFF});
		text_buf.push_back({1'b0, stt_pkg::CH_NL});
		text_buf.push_back({1'b0, stt_pkg::CH_DQUOTE});
		text_buf.push_back({1'b0, 8'h80});
		text_buf.push_back({1'b1, 8'h55});
		add_text("b-+");
		text_buf.push_back({1'b0, stt_pkg::CH_NUL});
		send_text();
		drain();
	endtask

	task automatic test_tab_widths();
		logic [4:0] widths [5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7};
		foreach (widths[i]) begin
			write_tab(widths[i]);
			add_text("\t x\t\t9\n\ty|");
			add_end();
			send_text();
		end
		drain();
	endtask

	// token length runs into its limit
	task automatic test_saturation();
		write_tab(5'd31);
		repeat (20) text_buf.push_back({1'b0, stt_pkg::CH_TAB});
		text_buf.push_back({1'b0, rand_letter()});
		repeat (259) text_buf.push_back({1'b0, stt_pkg::CH_UNDER});
		text_buf.push_back({1'b0, stt_pkg::CH_SPACE});
		add_digits(8);
		text_buf.push_back({1'b0, stt_pkg::CH_DQUOTE});
		repeat (258) text_buf.push_back({1'b0, 8'($urandom_range(35, 255))});
		text_buf.push_back({1'b0, stt_pkg::CH_DQUOTE});
		add_end();
		send_text();
		drain();
	endtask

	task automatic test_backpressure();
		sink_hold_left = 400;
		repeat (40) begin
			text_buf.push_back({1'b0, BRACKETS[$urandom_range(0, 5)]});
			add_text("a=b");
		end
		add_end();
		send_text();
		drain();
	endtask

	task automatic test_random(input int src_pct, input int sink_pct,
			input logic [4:0] tab, input int n_items);
		int sent;
		src_gap_pct = src_pct;
		sink_gap_pct = sink_pct;
		write_tab(tab);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(5, 30))
					text_buf.push_back({1'b0, 8'($urandom_range(1, 255))});
			end else begin
				repeat ($urandom_range(1, 20)) add_piece();
			end
			add_end();
			sent += text_buf.size();
			send_text();
		end
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tab_widths();
		test_saturation();
		test_backpressure();
		test_random(7, 86, 5'($urandom_range(1, 16)), 280);
		test_random(86, 7, 5'd16, 280);
		test_random(0, 0, 5'($urandom_range(0, 31)), 280);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
